>>> src/stf_pkg.sv
// Shared types and constants for the spaced-tap FIR filter.
package stf_pkg;

  // Fixed field widths and fixed-point formats.
  localparam int SAMPLE_WIDTH   = 16;
  localparam int WEIGHT_WIDTH   = 16;
  localparam int WEIGHT_FRAC    = 14;
  localparam int PROD_WIDTH     = SAMPLE_WIDTH + WEIGHT_WIDTH;
  // Room for the sum of up to six products plus the rounding offset.
  localparam int ACC_WIDTH      = PROD_WIDTH + 3;
  localparam int SPACING_WIDTH  = 6;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_IDX_WIDTH  = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TAP_SPACING  = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TAP_WEIGHT_0 = 3'd1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;

  // Weight of 1.0 in Q2.14, the reset value of the first tap.
  localparam weight_t WEIGHT_ONE = weight_t'(1 << WEIGHT_FRAC);

  // Saturation limits of a Q1.15 sample.
  localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});

  // Rounding offset: one half of the output LSB.
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (WEIGHT_FRAC - 1);

  typedef struct packed {
    sample_t sample_in;
    logic    block_end;
  } stf_in_t;

  typedef struct packed {
    sample_t sample_out;
    logic    block_end_out;
  } stf_out_t;

endpackage

>>> src/spaced_tap_fir_filter.sv
// Top level of the spaced-tap FIR filter: configuration, history cell chain, tap selection.
// An accepted input goes through the tap, multiply, pair, sum and output registers.
// Throughput: one transaction per cycle while out_ready_i allows, in a five-stage pipeline.
// The history is a chain of TAP_COUNT cells of MAX_SPACING samples that shifts once per input.
// Reset clears the whole history to zero at once, sets spacing 1 and weights 1.0, 0, 0, ...
// Inputs are accepted from the first cycle after reset.
module spaced_tap_fir_filter #(
  parameter int TAP_COUNT   = 6,
  parameter int MAX_SPACING = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  stf_pkg::stf_in_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output stf_pkg::stf_out_t                    out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [stf_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [stf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data_i
);
  import stf_pkg::*;

  localparam int HIST_DEPTH = TAP_COUNT * MAX_SPACING;
  localparam int DLY_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  logic [DLY_W-1:0] dly_q   [TAP_COUNT];
  logic [DLY_W-1:0] dly_new [TAP_COUNT];
  weight_t          weight_q [TAP_COUNT];
  sample_t          link    [TAP_COUNT];
  sample_t          cand    [TAP_COUNT][TAP_COUNT];
  sample_t          tap_val [TAP_COUNT];
  logic             in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  // Tap delays for a new spacing: tap m reads the sample (m+1)*K-1 back.
  always_comb begin
    int k;
    k = int'(cfg_data_i[SPACING_WIDTH-1:0]);
    if (k < 1) begin
      k = 1;
    end
    if (k > MAX_SPACING) begin
      k = MAX_SPACING;
    end
    for (int m = 0; m < TAP_COUNT; m++) begin
      dly_new[m] = DLY_W'(k * (m + 1) - 1);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < TAP_COUNT; m++) begin
        dly_q[m]    <= DLY_W'(m);
        weight_q[m] <= (m == 0) ? WEIGHT_ONE : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TAP_SPACING) begin
        dly_q <= dly_new;
      end
      for (int m = 0; m < TAP_COUNT; m++) begin
        if (cfg_idx_i == REG_TAP_WEIGHT_0 + CFG_IDX_WIDTH'(m)) begin
          weight_q[m] <= weight_t'(cfg_data_i[WEIGHT_WIDTH-1:0]);
        end
      end
    end
  end

  // Chain of history cells, newest samples in the first cell.
  assign link[0] = in_data_i.sample_in;

  for (genvar c = 0; c < TAP_COUNT; c++) begin : g_cell
    if (c < TAP_COUNT - 1) begin : g_mid
      stf_cell #(
        .SEG_LEN   (MAX_SPACING),
        .TAP_COUNT (TAP_COUNT),
        .DLY_W     (DLY_W),
        .BASE      (c * MAX_SPACING)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (in_accept),
        .sample_i  (link[c]),
        .sample_o  (link[c+1]),
        .tap_dly_i (dly_q),
        .cand_o    (cand[c])
      );
    end else begin : g_last
      stf_cell #(
        .SEG_LEN   (MAX_SPACING),
        .TAP_COUNT (TAP_COUNT),
        .DLY_W     (DLY_W),
        .BASE      (c * MAX_SPACING)
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (in_accept),
        .sample_i  (link[c]),
        .sample_o  (),
        .tap_dly_i (dly_q),
        .cand_o    (cand[c])
      );
    end
  end

  // Merge the cell offers; a zero delay reads the incoming sample itself.
  always_comb begin
    for (int m = 0; m < TAP_COUNT; m++) begin
      tap_val[m] = '0;
      for (int c = 0; c < TAP_COUNT; c++) begin
        tap_val[m] = tap_val[m] | cand[c][m];
      end
      if (dly_q[m] == '0) begin
        tap_val[m] = in_data_i.sample_in;
      end
    end
  end

  stf_mac #(
    .TAP_COUNT (TAP_COUNT)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .taps_i      (tap_val),
    .weight_i    (weight_q),
    .block_end_i (in_data_i.block_end),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/stf_cell.sv
// One segment of the sample history shift line with its local tap selection.
module stf_cell #(
  parameter int SEG_LEN   = 32,
  parameter int TAP_COUNT = 6,
  parameter int DLY_W     = 8,
  parameter int BASE      = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  stf_pkg::sample_t sample_i,
  output stf_pkg::sample_t sample_o,
  input  logic [DLY_W-1:0] tap_dly_i [TAP_COUNT],
  output stf_pkg::sample_t cand_o [TAP_COUNT]
);
  import stf_pkg::*;

  localparam int OFFS_W = (SEG_LEN > 1) ? $clog2(SEG_LEN) : 1;
  // This cell holds the samples of delay BASE+1 up to BASE+SEG_LEN.
  localparam logic [DLY_W:0] DLY_LO = (DLY_W+1)'(BASE);
  localparam logic [DLY_W:0] DLY_HI = (DLY_W+1)'(BASE + SEG_LEN);

  sample_t seg_q [SEG_LEN];

  // Shift the segment by one sample on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEG_LEN; i++) begin
        seg_q[i] <= '0;
      end
    end else if (shift_i) begin
      seg_q[0] <= sample_i;
      for (int i = 1; i < SEG_LEN; i++) begin
        seg_q[i] <= seg_q[i-1];
      end
    end
  end

  assign sample_o = seg_q[SEG_LEN-1];

  // Offer the sample of each tap whose delay falls inside this segment.
  always_comb begin
    logic [DLY_W:0] dly;
    logic [DLY_W:0] rel;
    for (int m = 0; m < TAP_COUNT; m++) begin
      dly = {1'b0, tap_dly_i[m]};
      rel = dly - DLY_LO - (DLY_W+1)'(1);
      if (dly > DLY_LO && dly <= DLY_HI) begin
        cand_o[m] = seg_q[rel[OFFS_W-1:0]];
      end else begin
        cand_o[m] = '0;
      end
    end
  end

endmodule

>>> src/stf_mac.sv
// Multiply, sum, round and saturate pipeline with per-stage flow control.
module stf_mac #(
  parameter int TAP_COUNT = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stf_pkg::sample_t  taps_i [TAP_COUNT],
  input  stf_pkg::weight_t  weight_i [TAP_COUNT],
  input  logic              block_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stf_pkg::stf_out_t out_data_o
);
  import stf_pkg::*;

  localparam int PAIRS    = (TAP_COUNT + 1) / 2;
  localparam int NSTG     = 5;
  localparam int ST_TAP   = 0;
  localparam int ST_MUL   = 1;
  localparam int ST_PAIR  = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_OUT   = 4;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] be_q;
  logic [NSTG-1:0] rdy;

  sample_t tap_q  [TAP_COUNT];
  prod_t   prod_q [TAP_COUNT];
  acc_t    pair_d [PAIRS];
  acc_t    pair_q [PAIRS];
  acc_t    sum_d;
  acc_t    sum_q;
  sample_t sat_d;
  sample_t out_q;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[ST_OUT] = !v_q[ST_OUT] || out_ready_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  assign in_ready_o = rdy[ST_TAP];

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[ST_TAP]) begin
        v_q[ST_TAP] <= in_valid_i;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Pairwise sums of the products.
  always_comb begin
    for (int p = 0; p < PAIRS; p++) begin
      pair_d[p] = '0;
    end
    for (int m = 0; m < TAP_COUNT; m++) begin
      pair_d[m >> 1] = pair_d[m >> 1] + acc_t'(prod_q[m]);
    end
  end

  // Final sum with the rounding offset folded in.
  always_comb begin
    sum_d = ROUND_HALF;
    for (int p = 0; p < PAIRS; p++) begin
      sum_d = sum_d + pair_q[p];
    end
  end

  // Drop the fraction bits and clamp to the sample range.
  always_comb begin
    acc_t                            sh;
    logic [ACC_WIDTH-SAMPLE_WIDTH:0] hi;
    sh = sum_q >>> WEIGHT_FRAC;
    hi = sh[ACC_WIDTH-1:SAMPLE_WIDTH-1];
    if (&hi || ~|hi) begin
      sat_d = sh[SAMPLE_WIDTH-1:0];
    end else if (sh[ACC_WIDTH-1]) begin
      sat_d = SAMPLE_MIN;
    end else begin
      sat_d = SAMPLE_MAX;
    end
  end

  // Stage data registers.
  always_ff @(posedge clk_i) begin
    if (rdy[ST_TAP]) begin
      tap_q          <= taps_i;
      be_q[ST_TAP]   <= block_end_i;
    end
    if (rdy[ST_MUL]) begin
      for (int m = 0; m < TAP_COUNT; m++) begin
        prod_q[m] <= tap_q[m] * weight_i[m];
      end
      be_q[ST_MUL] <= be_q[ST_TAP];
    end
    if (rdy[ST_PAIR]) begin
      pair_q        <= pair_d;
      be_q[ST_PAIR] <= be_q[ST_MUL];
    end
    if (rdy[ST_SUM]) begin
      sum_q        <= sum_d;
      be_q[ST_SUM] <= be_q[ST_PAIR];
    end
    if (rdy[ST_OUT]) begin
      out_q        <= sat_d;
      be_q[ST_OUT] <= be_q[ST_SUM];
    end
  end

  assign out_valid_o              = v_q[ST_OUT];
  assign out_data_o.sample_out    = out_q;
  assign out_data_o.block_end_out = be_q[ST_OUT];

endmodule

>>> test/stf_checker.sv
// Scoreboard for the spaced-tap FIR filter: mirrors the registers, predicts and compares results.
`timescale 1ns / 100ps

module stf_checker #(
  parameter int TAP_COUNT   = 6,
  parameter int MAX_SPACING = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  stf_pkg::stf_in_t                     in_data_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  stf_pkg::stf_out_t                    out_data_i,
  input  logic                                 cfg_we_i,
  input  logic [stf_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [stf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  import stf_pkg::*;

  localparam int HIST_DEPTH   = TAP_COUNT * MAX_SPACING;
  localparam int REPORT_LIMIT = 10;
  localparam int EXP_DEPTH    = 64;

  // Shadow copy of the filter registers and sample history.
  logic [SPACING_WIDTH-1:0] spacing_reg;
  weight_t                  weight_reg [TAP_COUNT];
  sample_t                  history [HIST_DEPTH];
  int unsigned              wr_pos;

  // Filtered samples still owed by the block, oldest first, kept in a ring.
  stf_out_t                 expected_mem [EXP_DEPTH];
  int                       exp_head;
  int                       exp_count;
  stf_out_t                 oldest;
  int                       mismatches;

  // Store one sample and compute the filtered, rounded and saturated output for it.
  function automatic stf_out_t filter_sample(input stf_in_t item);
    int unsigned k;
    int unsigned delay;
    int unsigned slot;
    int          m;
    longint      acc;
    longint      rounded;
    stf_out_t    res;
    k = spacing_reg;
    if (k < 1) k = 1;
    if (k > MAX_SPACING) k = MAX_SPACING;
    history[wr_pos] = item.sample_in;
    acc = 0;
    for (m = 0; m < TAP_COUNT; m++) begin
      delay = (k - 1) + m * k;
      slot  = (wr_pos + HIST_DEPTH - delay) % HIST_DEPTH;
      acc  += longint'(weight_reg[m]) * longint'(history[slot]);
    end
    wr_pos = (wr_pos + 1) % HIST_DEPTH;
    // Round half up, then clamp to the Q1.15 range.
    rounded = (acc + (longint'(1) <<< (WEIGHT_FRAC - 1))) >>> WEIGHT_FRAC;
    if (rounded > longint'(SAMPLE_MAX)) rounded = longint'(SAMPLE_MAX);
    if (rounded < longint'(SAMPLE_MIN)) rounded = longint'(SAMPLE_MIN);
    res.sample_out    = sample_t'(rounded);
    res.block_end_out = item.block_end;
    return res;
  endfunction

  // Track register writes, predict on each input transaction, check each output transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_reg = SPACING_WIDTH'(1);
      for (int i = 0; i < TAP_COUNT; i++) weight_reg[i] = '0;
      weight_reg[0] = WEIGHT_ONE;
      for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
      wr_pos = 0;
      exp_head  = 0;
      exp_count = 0;
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TAP_SPACING) begin
          spacing_reg = cfg_data_i[SPACING_WIDTH-1:0];
        end else if (cfg_idx_i >= REG_TAP_WEIGHT_0 &&
                     cfg_idx_i < REG_TAP_WEIGHT_0 + TAP_COUNT) begin
          weight_reg[cfg_idx_i - REG_TAP_WEIGHT_0] = weight_t'(cfg_data_i);
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (exp_count == EXP_DEPTH) begin
          // More transactions in flight than the block can ever hold.
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] too many outstanding transactions", $realtime);
          end
        end else begin
          expected_mem[(exp_head + exp_count) % EXP_DEPTH] = filter_sample(in_data_i);
          exp_count++;
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (exp_count == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] unexpected output: sample %0d end %0b", $realtime,
                     out_data_i.sample_out, out_data_i.block_end_out);
          end
        end else begin
          oldest    = expected_mem[exp_head];
          exp_head  = (exp_head + 1) % EXP_DEPTH;
          exp_count--;
          if (out_data_i.sample_out !== oldest.sample_out ||
              out_data_i.block_end_out !== oldest.block_end_out) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("[%0t] output mismatch: expected sample %0d end %0b, got sample %0d end %0b",
                       $realtime, oldest.sample_out, oldest.block_end_out,
                       out_data_i.sample_out, out_data_i.block_end_out);
            end
          end
        end
      end

      pending_o    <= exp_count;
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> test/tb.sv
// Testbench top for the spaced-tap FIR filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import stf_pkg::*;

  localparam int      LATENCY      = 5;
  localparam int      CYCLE_LIMIT  = 200000;
  localparam int      RAND_PHASES  = 12;
  localparam int      PHASE_ITEMS  = 120;
  localparam weight_t W_MAX        = 16'sh7FFF;
  localparam weight_t W_MIN        = 16'sh8000;
  // Index with no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED = 3'd7;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  stf_in_t                    in_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  stf_out_t                   out_data_o;
  logic                       cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0]   cfg_idx_i;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i;
  int                         fail_count;
  int                         pending;

  // Sender and receiver pacing state.
  int                         burst_left;
  logic                       valid_held;
  int unsigned                rcv_cycle;
  int unsigned                rcv_mode;
  int unsigned                cycles;

  // Register image written on the next reconfiguration.
  weight_t                    tap_w [6];

  spaced_tap_fir_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  stf_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: switches between randomly chosen stall patterns.
  always @(posedge clk_i) begin
    if (rcv_cycle % 300 == 0) rcv_mode = $urandom_range(0, 3);
    rcv_cycle++;
    case (rcv_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((rcv_cycle % 7) < 3);
    endcase
  end

  function automatic stf_in_t make_item(input sample_t s, input logic last);
    stf_in_t item;
    item.sample_in = s;
    item.block_end = last;
    return item;
  endfunction

  function automatic stf_in_t random_item();
    int unsigned sel;
    sample_t     s;
    sel = $urandom_range(0, 9);
    case (sel)
      0: s = SAMPLE_MAX;
      1: s = SAMPLE_MIN;
      2: s = sample_t'(int'($urandom_range(0, 64)) - 32);
      default: s = sample_t'($urandom);
    endcase
    return make_item(s, $urandom_range(0, 7) == 0);
  endfunction

  // Offer one input transaction and return once it is accepted and any gap closing the burst has passed.
  // Valid stays high into the next transaction unless a gap closes the burst.
  task automatic push_sample(input stf_in_t item);
    int gap_len;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    valid_held = 1'b1;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap_len    = $urandom_range(0, 5);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      if (gap_len > 0) begin
        in_valid_i <= 1'b0;
        valid_held = 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every expected result has come out.
  task automatic wait_idle();
    if (valid_held) in_valid_i <= 1'b0;
    valid_held = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // Write spacing, all six weights and one unmapped index, one register per cycle.
  task automatic apply_config(input logic [CFG_DATA_WIDTH-1:0] spacing_word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TAP_SPACING;
    cfg_data_i <= spacing_word;
    @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_idx_i  <= REG_TAP_WEIGHT_0 + CFG_IDX_WIDTH'(i);
      cfg_data_i <= tap_w[i];
      @(posedge clk_i);
    end
    cfg_idx_i  <= REG_UNMAPPED;
    cfg_data_i <= CFG_DATA_WIDTH'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int unsigned                spacing;
    int unsigned                wstyle;
    int unsigned                spacing_extremes [5];
    logic [CFG_DATA_WIDTH-1:0]  spacing_word;
    spacing_extremes = '{0, 1, 32, 33, 63};
    burst_left  = 1;
    valid_held  = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: unit gain on the current sample, so the output follows the input.
    push_sample(make_item(SAMPLE_MAX, 1'b1));
    push_sample(make_item(SAMPLE_MIN, 1'b0));
    push_sample(make_item(16'sd0, 1'b0));
    push_sample(make_item(16'sd1, 1'b0));
    push_sample(make_item(-16'sd1, 1'b1));
    push_sample(make_item(16'sh5555, 1'b0));
    push_sample(make_item(16'shAAAA, 1'b1));
    wait_idle();

    // Spacing zero behaves as one; full-scale weights drive both saturation limits.
    for (int i = 0; i < 6; i++) tap_w[i] = W_MAX;
    apply_config(16'd0);
    repeat (3) push_sample(make_item(SAMPLE_MAX, 1'b0));
    repeat (3) push_sample(make_item(SAMPLE_MIN, 1'b1));
    wait_idle();

    // Half-gain single tap: products of odd samples land exactly on rounding ties.
    for (int i = 0; i < 6; i++) tap_w[i] = '0;
    tap_w[0] = 16'sd8192;
    apply_config(16'd1);
    push_sample(make_item(16'sd1, 1'b0));
    push_sample(make_item(-16'sd1, 1'b0));
    push_sample(make_item(16'sd3, 1'b0));
    push_sample(make_item(-16'sd3, 1'b0));
    push_sample(make_item(SAMPLE_MIN, 1'b1));
    wait_idle();

    // Spacing above the maximum is clamped; most negative weights on every tap.
    for (int i = 0; i < 6; i++) tap_w[i] = W_MIN;
    apply_config(16'd33);
    repeat (4) push_sample(make_item(SAMPLE_MIN, 1'b0));
    repeat (3) push_sample(make_item(SAMPLE_MAX, 1'b1));
    wait_idle();

    // Random phases: new spacing and weights each time, history carried across.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 5)
        0: spacing = $urandom_range(1, 4);
        1: spacing = $urandom_range(0, 63);
        2: spacing = spacing_extremes[$urandom_range(0, 4)];
        3: spacing = $urandom_range(5, 32);
        default: spacing = $urandom_range(1, 2);
      endcase
      spacing_word = {10'($urandom), 6'(spacing)};
      wstyle = $urandom_range(0, 3);
      for (int i = 0; i < 6; i++) begin
        case (wstyle)
          0: tap_w[i] = weight_t'($urandom);
          1: tap_w[i] = weight_t'(int'($urandom_range(0, 4095)) - 2048);
          2: tap_w[i] = ($urandom_range(0, 2) == 0) ? weight_t'(0) : weight_t'($urandom);
          default: tap_w[i] = ($urandom_range(0, 1) == 1) ? W_MAX : W_MIN;
        endcase
      end
      apply_config(spacing_word);
      for (int n = 0; n < PHASE_ITEMS; n++) push_sample(random_item());
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
